[src/cis_pkg.sv]
// Shared types, constants and decode functions of the 8-bit processor core.
// Depends on nothing; the controller, the datapath and the top level import it.
package cis_pkg;

    localparam int ADDR_BITS = 16;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;
    localparam logic [47:0] TOTAL_MAX = '1;

    // Request commands.
    localparam logic [1:0] CMD_EXEC   = 2'd0;
    localparam logic [1:0] CMD_MEM_WR = 2'd1;
    localparam logic [1:0] CMD_MEM_RD = 2'd2;

    // Result event kinds.
    localparam logic [1:0] EV_FETCH = 2'd0;
    localparam logic [1:0] EV_READ  = 2'd1;
    localparam logic [1:0] EV_WRITE = 2'd2;
    localparam logic [1:0] EV_NONE  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_UNIMP = 2'd2;
    localparam logic [1:0] ST_MEM   = 2'd3;

    // ALU operation codes, taken from opcode bits 5:3.
    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_SUB = 3'd2;
    localparam logic [2:0] ALU_XOR = 3'd5;
    localparam logic [2:0] ALU_OR  = 3'd6;
    localparam logic [2:0] ALU_CP  = 3'd7;

    // Register index that selects the byte at HL.
    localparam logic [2:0] IDX_MEM = 3'd6;

    typedef enum logic [3:0] {
        AS_PC1, AS_PC2, AS_HL, AS_A16, AS_A16P, AS_SP, AS_SP1, AS_SPM1, AS_SPM2
    } cis_asel_t;

    typedef enum logic [3:0] {
        WD_NONE, WD_L, WD_H, WD_A, WD_PCH, WD_PCL, WD_IMM, WD_INCDEC, WD_SRC,
        WD_PUSHH, WD_PUSHL
    } cis_wsel_t;

    typedef enum logic [1:0] {DST_LO, DST_HI, DST_DLO, DST_DHI} cis_dst_t;

    typedef struct packed {
        cis_asel_t asel;
        logic      wr;
        cis_wsel_t wsel;
        cis_dst_t  dst;
    } cis_step_t;

    typedef struct packed {
        logic                  impl;
        logic                  halt;
        logic [2:0]            n_acc;
        cis_step_t [3:0]       steps;
    } cis_dec_t;

    typedef enum logic [2:0] {
        S_IDLE, S_MRD, S_DATA, S_NEXT, S_EMIT, S_ACC, S_EXEC, S_FIN
    } cis_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       mem_wr;
        logic       mem_rd;
        logic       fetch;
        logic       acc;
        cis_step_t  step;
        logic       capt;
        logic       exec;
        logic       impl;
        logic       emit;
        logic       last;
        logic [1:0] status;
    } cis_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [7:0] opcode;
    } cis_stat_t;

    function automatic cis_step_t cis_rd_step(input cis_asel_t asel, input cis_dst_t dst);
        cis_step_t s;
        s.asel = asel;
        s.wr   = 1'b0;
        s.wsel = WD_NONE;
        s.dst  = dst;
        return s;
    endfunction

    function automatic cis_step_t cis_wr_step(input cis_asel_t asel, input cis_wsel_t wsel);
        cis_step_t s;
        s.asel = asel;
        s.wr   = 1'b1;
        s.wsel = wsel;
        s.dst  = DST_LO;
        return s;
    endfunction

    // Lists the bus accesses that follow the opcode fetch, in order.
    function automatic cis_dec_t cis_decode(input logic [7:0] op);
        cis_dec_t   d;
        logic [2:0] idx;
        logic [2:0] src;
        idx = op[5:3];
        src = op[2:0];
        d = '0;
        d.impl = 1'b1;
        case (op)
            8'h00, 8'h23, 8'hEB:
            begin
                d.n_acc = 3'd0;
            end
            8'h01, 8'h11, 8'h21, 8'h31, 8'hC3:
            begin
                d.n_acc    = 3'd2;
                d.steps[0] = cis_rd_step(AS_PC1, DST_LO);
                d.steps[1] = cis_rd_step(AS_PC2, DST_HI);
            end
            8'h10, 8'h18, 8'h20, 8'h28, 8'h30, 8'h38,
            8'hC6, 8'hD6, 8'hEE, 8'hF6, 8'hFE:
            begin
                d.n_acc    = 3'd1;
                d.steps[0] = cis_rd_step(AS_PC1, DST_LO);
            end
            8'h22:
            begin
                d.n_acc    = 3'd4;
                d.steps[0] = cis_rd_step(AS_PC1, DST_LO);
                d.steps[1] = cis_rd_step(AS_PC2, DST_HI);
                d.steps[2] = cis_wr_step(AS_A16, WD_L);
                d.steps[3] = cis_wr_step(AS_A16P, WD_H);
            end
            8'h2A:
            begin
                d.n_acc    = 3'd4;
                d.steps[0] = cis_rd_step(AS_PC1, DST_LO);
                d.steps[1] = cis_rd_step(AS_PC2, DST_HI);
                d.steps[2] = cis_rd_step(AS_A16, DST_DLO);
                d.steps[3] = cis_rd_step(AS_A16P, DST_DHI);
            end
            8'h32:
            begin
                d.n_acc    = 3'd3;
                d.steps[0] = cis_rd_step(AS_PC1, DST_LO);
                d.steps[1] = cis_rd_step(AS_PC2, DST_HI);
                d.steps[2] = cis_wr_step(AS_A16, WD_A);
            end
            8'h3A:
            begin
                d.n_acc    = 3'd3;
                d.steps[0] = cis_rd_step(AS_PC1, DST_LO);
                d.steps[1] = cis_rd_step(AS_PC2, DST_HI);
                d.steps[2] = cis_rd_step(AS_A16, DST_DLO);
            end
            8'h76:
            begin
                d.halt = 1'b1;
            end
            8'hC1, 8'hD1, 8'hE1, 8'hF1, 8'hC9:
            begin
                d.n_acc    = 3'd2;
                d.steps[0] = cis_rd_step(AS_SP, DST_LO);
                d.steps[1] = cis_rd_step(AS_SP1, DST_HI);
            end
            8'hCD:
            begin
                d.n_acc    = 3'd4;
                d.steps[0] = cis_rd_step(AS_PC1, DST_LO);
                d.steps[1] = cis_rd_step(AS_PC2, DST_HI);
                d.steps[2] = cis_wr_step(AS_SPM1, WD_PCH);
                d.steps[3] = cis_wr_step(AS_SPM2, WD_PCL);
            end
            8'hC5, 8'hD5, 8'hE5, 8'hF5:
            begin
                d.n_acc    = 3'd2;
                d.steps[0] = cis_wr_step(AS_SPM1, WD_PUSHH);
                d.steps[1] = cis_wr_step(AS_SPM2, WD_PUSHL);
            end
            default:
            begin
                if (op[7:6] == 2'b00 && src == 3'd6)
                begin
                    d.steps[0] = cis_rd_step(AS_PC1, DST_LO);
                    d.n_acc    = 3'd1;
                    if (idx == IDX_MEM)
                    begin
                        d.steps[1] = cis_wr_step(AS_HL, WD_IMM);
                        d.n_acc    = 3'd2;
                    end
                end
                else if (op[7:6] == 2'b00 && (src inside {3'd4, 3'd5}))
                begin
                    if (idx == IDX_MEM)
                    begin
                        d.n_acc    = 3'd2;
                        d.steps[0] = cis_rd_step(AS_HL, DST_DLO);
                        d.steps[1] = cis_wr_step(AS_HL, WD_INCDEC);
                    end
                end
                else if (op[7:6] == 2'b01)
                begin
                    if (src == IDX_MEM)
                    begin
                        d.steps[0] = cis_rd_step(AS_HL, DST_DLO);
                        d.n_acc    = 3'd1;
                    end
                    if (idx == IDX_MEM)
                    begin
                        d.steps[d.n_acc[1:0]] = cis_wr_step(AS_HL, WD_SRC);
                        d.n_acc = d.n_acc + 3'd1;
                    end
                end
                else if (op[7:6] == 2'b10 && (idx inside {ALU_ADD, ALU_SUB, ALU_XOR,
                                                           ALU_OR, ALU_CP}))
                begin
                    if (src == IDX_MEM)
                    begin
                        d.n_acc    = 3'd1;
                        d.steps[0] = cis_rd_step(AS_HL, DST_DLO);
                    end
                end
                else
                begin
                    d.impl = 1'b0;
                end
            end
        endcase
        return d;
    endfunction

    // Sign, zero and the two copied bits of a result.
    function automatic logic [7:0] cis_szf(input logic [7:0] r);
        return {r[7], (r == 8'd0), r[5], 1'b0, r[3], 3'b000};
    endfunction

    // Returns {flags, result}.
    function automatic logic [15:0] cis_alu(input logic [2:0] kind, input logic [7:0] a,
                                            input logic [7:0] b);
        logic [8:0] s;
        logic [4:0] hs;
        logic [7:0] r;
        logic [7:0] f;
        s  = '0;
        hs = '0;
        r  = a;
        f  = '0;
        case (kind)
            ALU_ADD:
            begin
                s  = {1'b0, a} + {1'b0, b};
                hs = {1'b0, a[3:0]} + {1'b0, b[3:0]};
                r  = s[7:0];
                f  = cis_szf(r);
                f[4] = hs[4];
                f[2] = ~(a[7] ^ b[7]) & (a[7] ^ r[7]);
                f[0] = s[8];
            end
            ALU_SUB, ALU_CP:
            begin
                s  = {1'b0, a} - {1'b0, b};
                r  = s[7:0];
                f  = cis_szf(r);
                f[1] = 1'b1;
                f[4] = a[4] ^ b[4] ^ r[4];
                f[2] = (a[7] ^ b[7]) & (a[7] ^ r[7]);
                f[0] = s[8];
                if (kind == ALU_CP)
                begin
                    r = a;
                end
            end
            ALU_XOR, ALU_OR:
            begin
                r = (kind == ALU_XOR) ? (a ^ b) : (a | b);
                f = cis_szf(r);
                f[2] = ~(^r);
            end
            default:
            begin
                r = a;
            end
        endcase
        return {f, r};
    endfunction

    // Increment or decrement of one byte; returns {flags, result}.
    function automatic logic [15:0] cis_incdec(input logic [7:0] v, input logic dec,
                                               input logic cin);
        logic [7:0] r;
        logic [7:0] f;
        if (dec)
        begin
            r = v - 8'd1;
            f = cis_szf(r);
            f[1] = 1'b1;
            f[4] = (v[3:0] == 4'h0);
            f[2] = (v == 8'h80);
        end
        else
        begin
            r = v + 8'd1;
            f = cis_szf(r);
            f[4] = (v[3:0] == 4'hF);
            f[2] = (v == 8'h7F);
        end
        f[0] = cin;
        return {f, r};
    endfunction

endpackage

[src/cis_req_if.sv]
// Request channel of the processor core: command, address and data byte.
// Stands alone; no package needed.
interface cis_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;

    modport source (output valid, output command, output mem_address, output mem_data,
                    input ready);
    modport sink (input valid, input command, input mem_address, input mem_data,
                  output ready);
endinterface

[src/cis_rsp_if.sv]
// Result channel of the processor core: one bus event plus the final state.
// Stands alone; no package needed.
interface cis_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
    logic        last;
    logic [1:0]  status;
    logic [4:0]  step_tstates;
    logic [47:0] total_tstates;
    logic [15:0] program_counter;
    logic [15:0] stack_pointer;
    logic [7:0]  accumulator;
    logic [7:0]  flag_bits;
    logic [15:0] lowest_stack;

    modport source (output valid, output event_kind, output bus_address, output bus_data,
                    output last, output status, output step_tstates, output total_tstates,
                    output program_counter, output stack_pointer, output accumulator,
                    output flag_bits, output lowest_stack, input ready);
    modport sink (input valid, input event_kind, input bus_address, input bus_data,
                  input last, input status, input step_tstates, input total_tstates,
                  input program_counter, input stack_pointer, input accumulator,
                  input flag_bits, input lowest_stack, output ready);
endinterface

[src/cis_ctrl.sv]
// Sequencer of the processor core: walks fetch, bus accesses, execute and result.
// Depends on cis_pkg.
module cis_ctrl
    import cis_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_command,
    output logic       in_ready,
    input  logic       out_ready,
    output logic       out_valid,
    input  cis_stat_t  stat,
    output cis_cmd_t   cmd
);

    cis_state_t state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic [1:0] st_reg, st_next;
    logic       out_valid_reg, out_valid_next;
    cis_dec_t   dec;
    logic       out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            st_reg        <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        dec            = cis_decode(stat.opcode);
        out_free       = !out_valid_reg || out_ready;
        state_next     = state_reg;
        k_next         = k_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.impl       = dec.impl;
        cmd.step       = dec.steps[k_reg[1:0]];
        cmd.status     = st_reg;
        in_ready       = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_command)
                        CMD_EXEC:
                        begin
                            cmd.fetch  = 1'b1;
                            k_next     = '0;
                            state_next = S_DATA;
                        end
                        CMD_MEM_WR:
                        begin
                            cmd.mem_wr = 1'b1;
                            st_next    = ST_MEM;
                            state_next = S_FIN;
                        end
                        CMD_MEM_RD:
                        begin
                            cmd.mem_rd = 1'b1;
                            st_next    = ST_MEM;
                            state_next = S_MRD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MRD:
            begin
                cmd.capt   = 1'b1;
                state_next = S_FIN;
            end
            S_DATA:
            begin
                cmd.capt   = 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                st_next = !dec.impl ? ST_UNIMP : (dec.halt ? ST_HALT : ST_OK);
                state_next = (k_reg < dec.n_acc) ? S_EMIT : S_EXEC;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                k_next     = k_reg + 3'd1;
                state_next = S_DATA;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.last       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

[src/cis_dpath.sv]
// Datapath of the processor core: registers, memory, ALU and result register.
// Depends on cis_pkg.
module cis_dpath
    import cis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cis_cmd_t    cmd,
    input  logic [15:0] in_addr,
    input  logic [7:0]  in_data,
    output cis_stat_t   stat,
    output logic [1:0]  event_kind,
    output logic [15:0] bus_address,
    output logic [7:0]  bus_data,
    output logic        last,
    output logic [1:0]  status,
    output logic [4:0]  step_tstates,
    output logic [47:0] total_tstates,
    output logic [15:0] program_counter,
    output logic [15:0] stack_pointer,
    output logic [7:0]  accumulator,
    output logic [7:0]  flag_bits,
    output logic [15:0] lowest_stack
);

    logic [7:0]  mem [MEM_DEPTH];
    logic [7:0]  mem_rdata_reg;
    logic [15:0] mem_addr;
    logic        mem_we;
    logic [7:0]  mem_wdata;

    logic [7:0]  a_reg, f_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg;
    logic [7:0]  a_next, f_next, b_next, c_next, d_next, e_next, h_next, l_next;
    logic [15:0] sp_reg, sp_next, pc_reg, pc_next, min_reg;
    logic        min_valid_reg, note;
    logic [47:0] total_reg, total_next;
    logic [4:0]  cyc_reg, cyc_next;

    logic [7:0]  op_reg, lo_reg, hi_reg, dlo_reg, dhi_reg;
    logic [1:0]  ev_kind_reg;
    logic [15:0] ev_addr_reg;
    logic [7:0]  ev_data_reg;
    logic        ev_rd_reg, ev_fetch_reg, ev_take_reg;
    cis_dst_t    ev_dst_reg;

    logic [1:0]  out_kind_reg, out_status_reg;
    logic [15:0] out_addr_reg, out_pc_reg, out_sp_reg, out_min_reg;
    logic [7:0]  out_data_reg, out_a_reg, out_f_reg;
    logic        out_last_reg;
    logic [4:0]  out_cyc_reg;
    logic [47:0] out_total_reg;

    logic [2:0]  idx, src;
    logic [7:0]  src_val, idx_val, alu_b, bm, wval;
    logic [15:0] alu_res, id_res, a16, d16, hl, pc1, pc2, pc3, rel, push_val;
    logic [15:0] acc_addr;
    logic [7:0]  acc_wdata;
    logic        wen, pwen, taken;

    function automatic logic [7:0] sel8(input logic [2:0] i, input logic [7:0] rb,
                                        input logic [7:0] rc, input logic [7:0] rd,
                                        input logic [7:0] re, input logic [7:0] rh,
                                        input logic [7:0] rl, input logic [7:0] ra,
                                        input logic [7:0] rm);
        case (i)
            3'd0:    return rb;
            3'd1:    return rc;
            3'd2:    return rd;
            3'd3:    return re;
            3'd4:    return rh;
            3'd5:    return rl;
            3'd7:    return ra;
            default: return rm;
        endcase
    endfunction

    assign idx      = op_reg[5:3];
    assign src      = op_reg[2:0];
    assign hl       = {h_reg, l_reg};
    assign a16      = {hi_reg, lo_reg};
    assign d16      = {dhi_reg, dlo_reg};
    assign pc1      = pc_reg + 16'd1;
    assign pc2      = pc_reg + 16'd2;
    assign pc3      = pc_reg + 16'd3;
    assign rel      = pc2 + {{8{lo_reg[7]}}, lo_reg};
    assign src_val  = sel8(src, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, a_reg, dlo_reg);
    assign idx_val  = sel8(idx, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, a_reg, dlo_reg);
    assign alu_b    = (op_reg[7:6] == 2'b11) ? lo_reg : src_val;
    assign alu_res  = cis_alu(op_reg[5:3], a_reg, alu_b);
    assign id_res   = cis_incdec(idx_val, op_reg[0], f_reg[0]);
    assign bm       = b_reg - 8'd1;
    assign stat.opcode = op_reg;

    always_comb
    begin
        case (op_reg[5:4])
            2'd0:    push_val = {b_reg, c_reg};
            2'd1:    push_val = {d_reg, e_reg};
            2'd2:    push_val = hl;
            default: push_val = {a_reg, f_reg};
        endcase
    end

    // Address and write data of the current bus access.
    always_comb
    begin
        case (cmd.step.asel)
            AS_PC1:  acc_addr = pc1;
            AS_PC2:  acc_addr = pc2;
            AS_HL:   acc_addr = hl;
            AS_A16:  acc_addr = a16;
            AS_A16P: acc_addr = a16 + 16'd1;
            AS_SP:   acc_addr = sp_reg;
            AS_SP1:  acc_addr = sp_reg + 16'd1;
            AS_SPM1: acc_addr = sp_reg - 16'd1;
            AS_SPM2: acc_addr = sp_reg - 16'd2;
            default: acc_addr = pc_reg;
        endcase
        case (cmd.step.wsel)
            WD_L:      acc_wdata = l_reg;
            WD_H:      acc_wdata = h_reg;
            WD_A:      acc_wdata = a_reg;
            WD_PCH:    acc_wdata = pc3[15:8];
            WD_PCL:    acc_wdata = pc3[7:0];
            WD_IMM:    acc_wdata = lo_reg;
            WD_INCDEC: acc_wdata = id_res[7:0];
            WD_SRC:    acc_wdata = src_val;
            WD_PUSHH:  acc_wdata = push_val[15:8];
            WD_PUSHL:  acc_wdata = push_val[7:0];
            default:   acc_wdata = 8'd0;
        endcase
    end

    assign mem_addr  = (cmd.mem_wr || cmd.mem_rd) ? in_addr :
                       (cmd.fetch ? pc_reg : acc_addr);
    assign mem_we    = cmd.mem_wr || (cmd.acc && cmd.step.wr);
    assign mem_wdata = cmd.mem_wr ? in_data : acc_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr[ADDR_BITS-1:0]] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr[ADDR_BITS-1:0]];
    end

    // Architectural effect of one instruction, applied in the execute cycle.
    always_comb
    begin
        a_next = a_reg;
        f_next = f_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        h_next = h_reg;
        l_next = l_reg;
        sp_next  = sp_reg;
        pc_next  = pc_reg;
        cyc_next = '0;
        note  = 1'b0;
        wen   = 1'b0;
        wval  = lo_reg;
        pwen  = 1'b0;
        taken = 1'b0;
        if (cmd.impl)
        begin
            case (op_reg)
                8'h00, 8'h76:
                begin
                    pc_next = pc1;  cyc_next = 5'd4;
                end
                8'h01, 8'h11, 8'h21:
                begin
                    pwen = 1'b1;  pc_next = pc3;  cyc_next = 5'd10;
                end
                8'h31:
                begin
                    sp_next = a16;  note = 1'b1;  pc_next = pc3;  cyc_next = 5'd10;
                end
                8'h10:
                begin
                    b_next = bm;
                    pc_next  = (bm != 8'd0) ? rel : pc2;
                    cyc_next = (bm != 8'd0) ? 5'd13 : 5'd8;
                end
                8'h18:
                begin
                    pc_next = rel;  cyc_next = 5'd12;
                end
                8'h20, 8'h28, 8'h30, 8'h38:
                begin
                    taken    = ((op_reg[4] ? f_reg[0] : f_reg[6]) == op_reg[3]);
                    pc_next  = taken ? rel : pc2;
                    cyc_next = taken ? 5'd12 : 5'd7;
                end
                8'h22:
                begin
                    pc_next = pc3;  cyc_next = 5'd16;
                end
                8'h23:
                begin
                    pwen = 1'b1;  pc_next = pc1;  cyc_next = 5'd6;
                end
                8'h2A:
                begin
                    pwen = 1'b1;  pc_next = pc3;  cyc_next = 5'd16;
                end
                8'h32:
                begin
                    pc_next = pc3;  cyc_next = 5'd13;
                end
                8'h3A:
                begin
                    a_next = dlo_reg;  pc_next = pc3;  cyc_next = 5'd13;
                end
                8'hC3:
                begin
                    pc_next = a16;  cyc_next = 5'd10;
                end
                8'hC1, 8'hD1, 8'hE1:
                begin
                    pwen = 1'b1;  sp_next = sp_reg + 16'd2;  pc_next = pc1;
                    cyc_next = 5'd10;
                end
                8'hF1:
                begin
                    f_next = lo_reg;  a_next = hi_reg;  sp_next = sp_reg + 16'd2;
                    pc_next = pc1;  cyc_next = 5'd10;
                end
                8'hC9:
                begin
                    pc_next = a16;  sp_next = sp_reg + 16'd2;  cyc_next = 5'd10;
                end
                8'hCD:
                begin
                    sp_next = sp_reg - 16'd2;  note = 1'b1;  pc_next = a16;
                    cyc_next = 5'd17;
                end
                8'hEB:
                begin
                    d_next = h_reg;  e_next = l_reg;  h_next = d_reg;  l_next = e_reg;
                    pc_next = pc1;  cyc_next = 5'd4;
                end
                8'hC6, 8'hD6, 8'hEE, 8'hF6, 8'hFE:
                begin
                    {f_next, a_next} = alu_res;  pc_next = pc2;  cyc_next = 5'd7;
                end
                8'hC5, 8'hD5, 8'hE5, 8'hF5:
                begin
                    sp_next = sp_reg - 16'd2;  note = 1'b1;  pc_next = pc1;
                    cyc_next = 5'd11;
                end
                default:
                begin
                    if (op_reg[7:6] == 2'b00 && src == 3'd6)
                    begin
                        wen = (idx != IDX_MEM);  wval = lo_reg;  pc_next = pc2;
                        cyc_next = (idx == IDX_MEM) ? 5'd10 : 5'd7;
                    end
                    else if (op_reg[7:6] == 2'b00)
                    begin
                        f_next = id_res[15:8];
                        wen = (idx != IDX_MEM);  wval = id_res[7:0];  pc_next = pc1;
                        cyc_next = (idx == IDX_MEM) ? 5'd11 : 5'd4;
                    end
                    else if (op_reg[7:6] == 2'b01)
                    begin
                        wen = (idx != IDX_MEM);  wval = src_val;  pc_next = pc1;
                        cyc_next = (idx == IDX_MEM || src == IDX_MEM) ? 5'd7 : 5'd4;
                    end
                    else
                    begin
                        {f_next, a_next} = alu_res;  pc_next = pc1;
                        cyc_next = (src == IDX_MEM) ? 5'd7 : 5'd4;
                    end
                end
            endcase
            if (wen)
            begin
                case (idx)
                    3'd0:    b_next = wval;
                    3'd1:    c_next = wval;
                    3'd2:    d_next = wval;
                    3'd3:    e_next = wval;
                    3'd4:    h_next = wval;
                    3'd5:    l_next = wval;
                    3'd7:    a_next = wval;
                    default: a_next = a_reg;
                endcase
            end
            if (pwen)
            begin
                // The pair comes from the stack, an immediate, memory or HL plus one.
                case (op_reg)
                    8'h23:   {h_next, l_next} = hl + 16'd1;
                    8'h2A:   {h_next, l_next} = d16;
                    default:
                    begin
                        case (op_reg[5:4])
                            2'd0:    {b_next, c_next} = a16;
                            2'd1:    {d_next, e_next} = a16;
                            default: {h_next, l_next} = a16;
                        endcase
                    end
                endcase
            end
        end
        if (total_reg > TOTAL_MAX - {43'd0, cyc_next})
        begin
            total_next = TOTAL_MAX;
        end
        else
        begin
            total_next = total_reg + {43'd0, cyc_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;  f_reg <= '0;  b_reg <= '0;  c_reg <= '0;
            d_reg <= '0;  e_reg <= '0;  h_reg <= '0;  l_reg <= '0;
            sp_reg <= '0;  pc_reg <= '0;  total_reg <= '0;  cyc_reg <= '0;
            min_reg <= '0;  min_valid_reg <= 1'b0;
            ev_rd_reg <= 1'b0;  ev_fetch_reg <= 1'b0;  ev_take_reg <= 1'b0;
        end
        else
        begin
            if (cmd.mem_wr || cmd.mem_rd)
            begin
                cyc_reg      <= '0;
                ev_rd_reg    <= cmd.mem_rd;
                ev_fetch_reg <= 1'b0;
                ev_take_reg  <= 1'b0;
            end
            if (cmd.fetch)
            begin
                ev_rd_reg    <= 1'b1;
                ev_fetch_reg <= 1'b1;
                ev_take_reg  <= 1'b0;
            end
            if (cmd.acc)
            begin
                ev_rd_reg    <= !cmd.step.wr;
                ev_fetch_reg <= 1'b0;
                ev_take_reg  <= !cmd.step.wr;
            end
            if (cmd.exec)
            begin
                a_reg <= a_next;  f_reg <= f_next;  b_reg <= b_next;  c_reg <= c_next;
                d_reg <= d_next;  e_reg <= e_next;  h_reg <= h_next;  l_reg <= l_next;
                sp_reg <= sp_next;  pc_reg <= pc_next;
                cyc_reg <= cyc_next;  total_reg <= total_next;
                if (note && (!min_valid_reg || sp_next < min_reg))
                begin
                    min_reg       <= sp_next;
                    min_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Event capture, operand temporaries and the result register.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr || cmd.mem_rd)
        begin
            ev_kind_reg <= EV_NONE;
            ev_addr_reg <= in_addr;
            ev_data_reg <= in_data;
        end
        if (cmd.fetch)
        begin
            ev_kind_reg <= EV_FETCH;
            ev_addr_reg <= pc_reg;
        end
        if (cmd.acc)
        begin
            ev_kind_reg <= cmd.step.wr ? EV_WRITE : EV_READ;
            ev_addr_reg <= acc_addr;
            ev_data_reg <= acc_wdata;
            ev_dst_reg  <= cmd.step.dst;
        end
        if (cmd.capt && ev_rd_reg)
        begin
            ev_data_reg <= mem_rdata_reg;
            if (ev_fetch_reg)
            begin
                op_reg <= mem_rdata_reg;
            end
            if (ev_take_reg)
            begin
                case (ev_dst_reg)
                    DST_LO:  lo_reg  <= mem_rdata_reg;
                    DST_HI:  hi_reg  <= mem_rdata_reg;
                    DST_DLO: dlo_reg <= mem_rdata_reg;
                    default: dhi_reg <= mem_rdata_reg;
                endcase
            end
        end
        if (cmd.emit)
        begin
            out_kind_reg <= ev_kind_reg;
            out_addr_reg <= ev_addr_reg;
            out_data_reg <= ev_data_reg;
            out_last_reg <= cmd.last;
            if (cmd.last)
            begin
                out_status_reg <= cmd.status;
                out_cyc_reg    <= cyc_reg;
                out_total_reg  <= total_reg;
                out_pc_reg     <= pc_reg;
                out_sp_reg     <= sp_reg;
                out_a_reg      <= a_reg;
                out_f_reg      <= f_reg;
                out_min_reg    <= min_reg;
            end
            else
            begin
                out_status_reg <= '0;
                out_cyc_reg    <= '0;
                out_total_reg  <= '0;
                out_pc_reg     <= '0;
                out_sp_reg     <= '0;
                out_a_reg      <= '0;
                out_f_reg      <= '0;
                out_min_reg    <= '0;
            end
        end
    end

    assign event_kind      = out_kind_reg;
    assign bus_address     = out_addr_reg;
    assign bus_data        = out_data_reg;
    assign last            = out_last_reg;
    assign status          = out_status_reg;
    assign step_tstates    = out_cyc_reg;
    assign total_tstates   = out_total_reg;
    assign program_counter = out_pc_reg;
    assign stack_pointer   = out_sp_reg;
    assign accumulator     = out_a_reg;
    assign flag_bits       = out_f_reg;
    assign lowest_stack    = out_min_reg;

endmodule

[src/cpu_instruction_step_subset.sv]
// Top level of the 8-bit processor core; depends on cis_pkg, cis_req_if, cis_rsp_if,
// cis_ctrl and cis_dpath. An execute request runs the opcode fetch, then each listed
// access in turn on the single-port memory with its registered read, once per access;
// results leave through one result register. A memory read captures its byte first.
// Reset (rst_n low, asynchronous) clears all processor registers and totals; memory
// content stays undefined until written.
module cpu_instruction_step_subset
    import cis_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    cis_req_if.sink  req,
    cis_rsp_if.source rsp
);

    cis_cmd_t  cmd;
    cis_stat_t stat;

    // The controller sequences each request: the opcode fetch, then the accesses
    // that the decoded opcode lists, one at a time. Every access becomes one result.
    // A result is held back until the next access is known to exist, so that the
    // final one can carry the processor state after the execute cycle.
    cis_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_command (req.command),
        .in_ready   (req.ready),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .stat       (stat),
        .cmd        (cmd)
    );

    // The datapath holds the memory, the register file, the ALU and the
    // result register that drives the result channel.
    cis_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .in_addr         (req.mem_address),
        .in_data         (req.mem_data),
        .stat            (stat),
        .event_kind      (rsp.event_kind),
        .bus_address     (rsp.bus_address),
        .bus_data        (rsp.bus_data),
        .last            (rsp.last),
        .status          (rsp.status),
        .step_tstates    (rsp.step_tstates),
        .total_tstates   (rsp.total_tstates),
        .program_counter (rsp.program_counter),
        .stack_pointer   (rsp.stack_pointer),
        .accumulator     (rsp.accumulator),
        .flag_bits       (rsp.flag_bits),
        .lowest_stack    (rsp.lowest_stack)
    );

    // Results that are not final carry no processor state.
    a_nonlast_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.last |-> rsp.status == ST_OK && rsp.step_tstates == 5'd0)
        else $error("non-final result carries state");

    // A memory request answers with a single event that is not a bus cycle.
    a_mem_event: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_MEM |-> rsp.last && rsp.event_kind == EV_NONE)
        else $error("memory request result malformed");

    // An unknown opcode reports only its fetch and charges no clock states.
    a_unimp_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.last && rsp.status == ST_UNIMP |->
            rsp.event_kind == EV_FETCH && rsp.step_tstates == 5'd0)
        else $error("unimplemented opcode result malformed");

    // No request is taken while the sequencer still works on the previous one.
    a_busy_no_req: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !req.ready)
        else $error("request taken during execute");

endmodule

[tb/tb_cpu_instruction_step_subset.sv]
// Self-checking testbench of the 8-bit processor core with its own memory.
// Depends on cis_pkg, cis_req_if, cis_rsp_if and cpu_instruction_step_subset.
// Random programs are run one request at a time and every bus event is compared with a shadow core.
module tb_cpu_instruction_step_subset;
    import cis_pkg::*;

    // Command code that the core ignores without any result.
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    // Opcodes named by the directed part and by the shadow core.
    localparam logic [7:0] OP_NOP     = 8'h00;
    localparam logic [7:0] OP_LD_BCNN = 8'h01;
    localparam logic [7:0] OP_DJNZ    = 8'h10;
    localparam logic [7:0] OP_LD_DENN = 8'h11;
    localparam logic [7:0] OP_JR      = 8'h18;
    localparam logic [7:0] OP_JR_NZ   = 8'h20;
    localparam logic [7:0] OP_LD_HLNN = 8'h21;
    localparam logic [7:0] OP_ST_HL   = 8'h22;
    localparam logic [7:0] OP_INC_HL  = 8'h23;
    localparam logic [7:0] OP_JR_Z    = 8'h28;
    localparam logic [7:0] OP_LD_HLM  = 8'h2A;
    localparam logic [7:0] OP_JR_NC   = 8'h30;
    localparam logic [7:0] OP_LD_SP   = 8'h31;
    localparam logic [7:0] OP_ST_A    = 8'h32;
    localparam logic [7:0] OP_INC_M   = 8'h34;
    localparam logic [7:0] OP_LD_MN   = 8'h36;
    localparam logic [7:0] OP_JR_C    = 8'h38;
    localparam logic [7:0] OP_LD_AM   = 8'h3A;
    localparam logic [7:0] OP_INC_A   = 8'h3C;
    localparam logic [7:0] OP_DEC_A   = 8'h3D;
    localparam logic [7:0] OP_LD_AN   = 8'h3E;
    localparam logic [7:0] OP_LD_BN   = 8'h06;
    localparam logic [7:0] OP_HALT    = 8'h76;
    localparam logic [7:0] OP_LD_MA   = 8'h77;
    localparam logic [7:0] OP_ADD_M   = 8'h86;
    localparam logic [7:0] OP_SUB_B   = 8'h90;
    localparam logic [7:0] OP_CP_M    = 8'hBE;
    localparam logic [7:0] OP_POP_BC  = 8'hC1;
    localparam logic [7:0] OP_JP      = 8'hC3;
    localparam logic [7:0] OP_ADD_N   = 8'hC6;
    localparam logic [7:0] OP_RET     = 8'hC9;
    localparam logic [7:0] OP_CALL    = 8'hCD;
    localparam logic [7:0] OP_POP_DE  = 8'hD1;
    localparam logic [7:0] OP_SUB_N   = 8'hD6;
    localparam logic [7:0] OP_POP_HL  = 8'hE1;
    localparam logic [7:0] OP_PUSH_HL = 8'hE5;
    localparam logic [7:0] OP_EX_DEHL = 8'hEB;
    localparam logic [7:0] OP_XOR_N   = 8'hEE;
    localparam logic [7:0] OP_POP_AF  = 8'hF1;
    localparam logic [7:0] OP_PUSH_AF = 8'hF5;
    localparam logic [7:0] OP_OR_N    = 8'hF6;
    localparam logic [7:0] OP_CP_N    = 8'hFE;
    localparam logic [7:0] OP_PREFIX  = 8'hED;

    // Opcode pattern masks and their matching values.
    localparam logic [7:0] MASK_PUSH = 8'hCF;
    localparam logic [7:0] PAT_PUSH  = 8'hC5;
    localparam logic [7:0] MASK_REG  = 8'hC7;
    localparam logic [7:0] PAT_LDN   = 8'h06;
    localparam logic [7:0] PAT_INC   = 8'h04;
    localparam logic [7:0] PAT_DEC   = 8'h05;

    // Flag bits.
    localparam logic [7:0] FL_S  = 8'h80;
    localparam logic [7:0] FL_Z  = 8'h40;
    localparam logic [7:0] FL_H  = 8'h10;
    localparam logic [7:0] FL_PV = 8'h04;
    localparam logic [7:0] FL_N  = 8'h02;
    localparam logic [7:0] FL_C  = 8'h01;

    typedef struct {
        logic [1:0]  command;
        logic [15:0] mem_address;
        logic [7:0]  mem_data;
    } cpu_request_t;

    typedef struct {
        logic [1:0]  event_kind;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
        logic        last;
        logic [1:0]  status;
        logic [4:0]  step_tstates;
        logic [47:0] total_tstates;
        logic [15:0] program_counter;
        logic [15:0] stack_pointer;
        logic [7:0]  accumulator;
        logic [7:0]  flag_bits;
        logic [15:0] lowest_stack;
    } bus_event_t;

    logic clk;
    logic rst_n;

    cis_req_if req ();
    cis_rsp_if rsp ();

    cpu_instruction_step_subset dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Requests waiting to be offered, and bus events still owed by the core.
    cpu_request_t pending_requests[$];
    bus_event_t   owed_events[$];

    int  fail_count;
    bit  quiet_phase;     // no idling on either side near the end of the run
    int  hold_off_cycles; // a long receiver stall, counted down by the result side
    int  send_gap;
    int  take_gap;

    // Shadow copy of the core state. Memory holds X until written, and the
    // written map keeps the stimulus from ever reading such a byte.
    logic [7:0]  shadow_mem [0:65535];
    bit          mem_written [0:65535];
    logic [7:0]  reg_a;
    logic [7:0]  reg_f;
    logic [7:0]  reg_bank [0:5];
    logic [15:0] reg_sp;
    logic [15:0] reg_pc;
    bit          halted;
    logic [47:0] tstate_sum;
    logic [15:0] low_sp;
    bit          low_sp_seen;

    // Bus accesses of the request that is being predicted.
    int          access_count;
    logic [1:0]  access_kind [0:4];
    logic [15:0] access_addr [0:4];
    logic [7:0]  access_data [0:4];

    // Bytes that the stimulus has queued in the current bundle but not yet sent.
    logic [7:0]  planned_bytes [int];

    //------------------------------------------------------------------
    // Shadow core
    //------------------------------------------------------------------

    function automatic void log_access(logic [1:0] kind, logic [15:0] addr, logic [7:0] data);
        if (access_count < 5)
        begin
            access_kind[access_count] = kind;
            access_addr[access_count] = addr;
            access_data[access_count] = data;
            access_count++;
        end
    endfunction

    function automatic logic [7:0] bus_read(logic [15:0] addr, logic [1:0] kind);
        log_access(kind, addr, shadow_mem[addr]);
        return shadow_mem[addr];
    endfunction

    function automatic void bus_write(logic [15:0] addr, logic [7:0] data);
        shadow_mem[addr]  = data;
        mem_written[addr] = 1'b1;
        log_access(EV_WRITE, addr, data);
    endfunction

    function automatic logic [15:0] read_word(logic [15:0] addr)
        ;
        logic [7:0] lo;
        logic [7:0] hi;
        lo = bus_read(addr, EV_READ);
        hi = bus_read(addr + 16'd1, EV_READ);
        return {hi, lo};
    endfunction

    // Register pairs: 0 BC, 1 DE, 2 HL.
    function automatic logic [15:0] pair_value(logic [1:0] p);
        return {reg_bank[2 * p], reg_bank[2 * p + 1]};
    endfunction

    function automatic void pair_load(logic [1:0] p, logic [15:0] v);
        reg_bank[2 * p]     = v[15:8];
        reg_bank[2 * p + 1] = v[7:0];
    endfunction

    // Register index 6 is the byte at HL, 7 the accumulator.
    function automatic logic [7:0] operand_read(logic [2:0] i);
        if (i == IDX_MEM)
            return bus_read(pair_value(2), EV_READ);
        if (i == 3'd7)
            return reg_a;
        return reg_bank[i];
    endfunction

    function automatic void operand_write(logic [2:0] i, logic [7:0] v);
        if (i == IDX_MEM)
            bus_write(pair_value(2), v);
        else if (i == 3'd7)
            reg_a = v;
        else
            reg_bank[i] = v;
    endfunction

    function automatic void track_low_sp();
        if (!low_sp_seen || reg_sp < low_sp)
        begin
            low_sp      = reg_sp;
            low_sp_seen = 1'b1;
        end
    endfunction

    function automatic void push_word(logic [15:0] v);
        reg_sp = reg_sp - 16'd1;
        bus_write(reg_sp, v[15:8]);
        reg_sp = reg_sp - 16'd1;
        bus_write(reg_sp, v[7:0]);
        track_low_sp();
    endfunction

    function automatic logic [15:0] pop_word();
        logic [15:0] v;
        v = read_word(reg_sp);
        reg_sp = reg_sp + 16'd2;
        return v;
    endfunction

    function automatic logic [7:0] sign_zero_flags(logic [7:0] r);
        return (r & 8'hA8) | ((r == 8'd0) ? FL_Z : 8'd0);
    endfunction

    // The operation code is opcode bits 5:3, the same for register and immediate forms.
    function automatic void arith(logic [2:0] kind, logic [7:0] b);
        logic [8:0] wide;
        logic [7:0] r;
        logic [7:0] fl;
        case (kind)
            ALU_ADD:
            begin
                wide = {1'b0, reg_a} + {1'b0, b};
                r    = wide[7:0];
                fl   = sign_zero_flags(r);
                if ((reg_a[3:0] + b[3:0]) > 5'd15) fl |= FL_H;
                if (~(reg_a[7] ^ b[7]) & (reg_a[7] ^ r[7])) fl |= FL_PV;
                if (wide[8]) fl |= FL_C;
            end
            ALU_SUB, ALU_CP:
            begin
                wide = {1'b0, reg_a} - {1'b0, b};
                r    = wide[7:0];
                fl   = sign_zero_flags(r) | FL_N;
                if ((reg_a[4] ^ b[4] ^ r[4])) fl |= FL_H;
                if ((reg_a[7] ^ b[7]) & (reg_a[7] ^ r[7])) fl |= FL_PV;
                if (wide[8]) fl |= FL_C;
                // Compare only sets the flags.
                if (kind == ALU_CP) r = reg_a;
            end
            default:
            begin
                r  = (kind == ALU_XOR) ? (reg_a ^ b) : (reg_a | b);
                fl = sign_zero_flags(r);
                if (~^r) fl |= FL_PV;
            end
        endcase
        reg_f = fl;
        reg_a = r;
    endfunction

    function automatic logic [15:0] branch_target(logic [15:0] pc, logic [7:0] d);
        return pc + 16'd2 + {{8{d[7]}}, d};
    endfunction

    // Runs one instruction; returns the status and the clock states charged.
    function automatic logic [1:0] run_instruction(output logic [4:0] cyc);
        logic [15:0] pc;
        logic [7:0]  op;
        logic [7:0]  imm;
        logic [7:0]  v;
        logic [7:0]  r;
        logic [7:0]  fl;
        logic [15:0] w;
        logic [2:0]  idx;
        logic [2:0]  src;
        logic [1:0]  p;
        bit          taken;
        pc  = reg_pc;
        op  = bus_read(pc, EV_FETCH);
        idx = op[5:3];
        src = op[2:0];
        cyc = 5'd0;
        case (op)
            OP_NOP:
            begin
                reg_pc = pc + 16'd1; cyc = 5'd4;
            end
            OP_LD_BCNN, OP_LD_DENN, OP_LD_HLNN:
            begin
                pair_load(op[5:4], read_word(pc + 16'd1));
                reg_pc = pc + 16'd3; cyc = 5'd10;
            end
            OP_LD_SP:
            begin
                reg_sp = read_word(pc + 16'd1);
                track_low_sp();
                reg_pc = pc + 16'd3; cyc = 5'd10;
            end
            OP_DJNZ:
            begin
                imm = bus_read(pc + 16'd1, EV_READ);
                reg_bank[0] = reg_bank[0] - 8'd1;
                if (reg_bank[0] != 8'd0)
                begin
                    reg_pc = branch_target(pc, imm); cyc = 5'd13;
                end
                else
                begin
                    reg_pc = pc + 16'd2; cyc = 5'd8;
                end
            end
            OP_JR:
            begin
                imm = bus_read(pc + 16'd1, EV_READ);
                reg_pc = branch_target(pc, imm); cyc = 5'd12;
            end
            OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C:
            begin
                // Bit 4 picks carry over zero, bit 3 the wanted state.
                imm   = bus_read(pc + 16'd1, EV_READ);
                taken = ((op[4] ? reg_f[0] : reg_f[6]) == op[3]);
                if (taken)
                begin
                    reg_pc = branch_target(pc, imm); cyc = 5'd12;
                end
                else
                begin
                    reg_pc = pc + 16'd2; cyc = 5'd7;
                end
            end
            OP_ST_HL:
            begin
                w = read_word(pc + 16'd1);
                bus_write(w, reg_bank[5]);
                bus_write(w + 16'd1, reg_bank[4]);
                reg_pc = pc + 16'd3; cyc = 5'd16;
            end
            OP_INC_HL:
            begin
                pair_load(2, pair_value(2) + 16'd1);
                reg_pc = pc + 16'd1; cyc = 5'd6;
            end
            OP_LD_HLM:
            begin
                w = read_word(pc + 16'd1);
                pair_load(2, read_word(w));
                reg_pc = pc + 16'd3; cyc = 5'd16;
            end
            OP_ST_A:
            begin
                w = read_word(pc + 16'd1);
                bus_write(w, reg_a);
                reg_pc = pc + 16'd3; cyc = 5'd13;
            end
            OP_LD_AM:
            begin
                w = read_word(pc + 16'd1);
                reg_a = bus_read(w, EV_READ);
                reg_pc = pc + 16'd3; cyc = 5'd13;
            end
            OP_HALT:
            begin
                halted = 1'b1;
                reg_pc = pc + 16'd1; cyc = 5'd4;
                return ST_HALT;
            end
            OP_JP:
            begin
                reg_pc = read_word(pc + 16'd1); cyc = 5'd10;
            end
            OP_POP_BC, OP_POP_DE, OP_POP_HL:
            begin
                pair_load(op[5:4], pop_word());
                reg_pc = pc + 16'd1; cyc = 5'd10;
            end
            OP_POP_AF:
            begin
                w = pop_word();
                reg_f = w[7:0];
                reg_a = w[15:8];
                reg_pc = pc + 16'd1; cyc = 5'd10;
            end
            OP_RET:
            begin
                reg_pc = pop_word(); cyc = 5'd10;
            end
            OP_CALL:
            begin
                w = read_word(pc + 16'd1);
                push_word(pc + 16'd3);
                reg_pc = w; cyc = 5'd17;
            end
            OP_EX_DEHL:
            begin
                w = pair_value(1);
                pair_load(1, pair_value(2));
                pair_load(2, w);
                reg_pc = pc + 16'd1; cyc = 5'd4;
            end
            OP_ADD_N, OP_SUB_N, OP_XOR_N, OP_OR_N, OP_CP_N:
            begin
                imm = bus_read(pc + 16'd1, EV_READ);
                arith(idx, imm);
                reg_pc = pc + 16'd2; cyc = 5'd7;
            end
            default:
            begin
                if ((op & MASK_PUSH) == PAT_PUSH)
                begin
                    p = op[5:4];
                    push_word((p == 2'd3) ? {reg_a, reg_f} : pair_value(p));
                    reg_pc = pc + 16'd1; cyc = 5'd11;
                end
                else if ((op & MASK_REG) == PAT_LDN)
                begin
                    imm = bus_read(pc + 16'd1, EV_READ);
                    operand_write(idx, imm);
                    reg_pc = pc + 16'd2; cyc = (idx == IDX_MEM) ? 5'd10 : 5'd7;
                end
                else if ((op & MASK_REG) == PAT_INC || (op & MASK_REG) == PAT_DEC)
                begin
                    // Carry is kept; half carry and overflow come from the old value.
                    v  = operand_read(idx);
                    fl = reg_f & FL_C;
                    if (!op[0])
                    begin
                        r = v + 8'd1;
                        fl |= sign_zero_flags(r);
                        if (v[3:0] == 4'hF) fl |= FL_H;
                        if (v == 8'h7F) fl |= FL_PV;
                    end
                    else
                    begin
                        r = v - 8'd1;
                        fl |= sign_zero_flags(r) | FL_N;
                        if (v[3:0] == 4'h0) fl |= FL_H;
                        if (v == 8'h80) fl |= FL_PV;
                    end
                    reg_f = fl;
                    operand_write(idx, r);
                    reg_pc = pc + 16'd1; cyc = (idx == IDX_MEM) ? 5'd11 : 5'd4;
                end
                else if (op[7:6] == 2'b01)
                begin
                    v = operand_read(src);
                    operand_write(idx, v);
                    reg_pc = pc + 16'd1;
                    cyc = (idx == IDX_MEM || src == IDX_MEM) ? 5'd7 : 5'd4;
                end
                else if (op[7:6] == 2'b10 &&
                         (idx == ALU_ADD || idx == ALU_SUB || idx == ALU_XOR ||
                          idx == ALU_OR || idx == ALU_CP))
                begin
                    v = operand_read(src);
                    arith(idx, v);
                    reg_pc = pc + 16'd1; cyc = (src == IDX_MEM) ? 5'd7 : 5'd4;
                end
                else
                begin
                    // Not in the subset: only the fetch shows, the pc stays put.
                    return ST_UNIMP;
                end
            end
        endcase
        return ST_OK;
    endfunction

    // Works out the bus events of one accepted request and queues them.
    function automatic void predict_request(logic [1:0] cmd, logic [15:0] addr,
                                            logic [7:0] data);
        logic [1:0] st;
        logic [4:0] cyc;
        bus_event_t ev;
        access_count = 0;
        cyc = 5'd0;
        case (cmd)
            CMD_MEM_WR:
            begin
                shadow_mem[addr]  = data;
                mem_written[addr] = 1'b1;
                log_access(EV_NONE, addr, data);
                st = ST_MEM;
            end
            CMD_MEM_RD:
            begin
                log_access(EV_NONE, addr, shadow_mem[addr]);
                st = ST_MEM;
            end
            CMD_EXEC:
            begin
                st = run_instruction(cyc);
                if (tstate_sum > TOTAL_MAX - cyc)
                    tstate_sum = TOTAL_MAX;
                else
                    tstate_sum = tstate_sum + cyc;
            end
            default:
            begin
                return;
            end
        endcase
        for (int k = 0; k < access_count; k++)
        begin
            ev = '{default: '0};
            ev.event_kind  = access_kind[k];
            ev.bus_address = access_addr[k];
            ev.bus_data    = access_data[k];
            if (k == access_count - 1)
            begin
                ev.last            = 1'b1;
                ev.status          = st;
                ev.step_tstates    = cyc;
                ev.total_tstates   = tstate_sum;
                ev.program_counter = reg_pc;
                ev.stack_pointer   = reg_sp;
                ev.accumulator     = reg_a;
                ev.flag_bits       = reg_f;
                ev.lowest_stack    = low_sp;
            end
            owed_events.push_back(ev);
        end
    endfunction

    //------------------------------------------------------------------
    // Clock, reset and time limit
    //------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Far beyond the slowest legal run: every request waiting out the
    // longest stalls on both sides plus the long receiver hold-off.
    initial
    begin
        #(20 * 2000000);
        $display("[FAIL] regression broken");
        $finish;
    end

    //------------------------------------------------------------------
    // Request driver. The shadow core advances on each accepted request,
    // using the values that were on the channel at that edge.
    //------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        cpu_request_t nxt;
        if (!rst_n)
        begin
            req.valid       <= 1'b0;
            req.command     <= CMD_EXEC;
            req.mem_address <= '0;
            req.mem_data    <= '0;
            send_gap = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                predict_request(req.command, req.mem_address, req.mem_data);

            if (req.valid && !req.ready)
            begin
                // The request on the channel stays until it is taken.
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                req.valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                nxt = pending_requests.pop_front();
                req.valid       <= 1'b1;
                req.command     <= nxt.command;
                req.mem_address <= nxt.mem_address;
                req.mem_data    <= nxt.mem_data;
                if (!quiet_phase && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 18);
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // Result monitor and receiver back-pressure
    //------------------------------------------------------------------

    task automatic compare_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bus_event_t want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (owed_events.size() == 0)
                begin
                    $display("%0t: result with nothing expected, expected none actual %0h/%0h",
                             $time, rsp.event_kind, rsp.bus_address);
                    fail_count++;
                end
                else
                begin
                    want = owed_events.pop_front();
                    compare_field("event_kind", want.event_kind, rsp.event_kind);
                    compare_field("bus_address", want.bus_address, rsp.bus_address);
                    compare_field("bus_data", want.bus_data, rsp.bus_data);
                    compare_field("last", want.last, rsp.last);
                    compare_field("status", want.status, rsp.status);
                    compare_field("step_tstates", want.step_tstates, rsp.step_tstates);
                    compare_field("total_tstates", want.total_tstates, rsp.total_tstates);
                    compare_field("program_counter", want.program_counter,
                                  rsp.program_counter);
                    compare_field("stack_pointer", want.stack_pointer, rsp.stack_pointer);
                    compare_field("accumulator", want.accumulator, rsp.accumulator);
                    compare_field("flag_bits", want.flag_bits, rsp.flag_bits);
                    compare_field("lowest_stack", want.lowest_stack, rsp.lowest_stack);
                end
            end

            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                rsp.ready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap--;
                rsp.ready <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                take_gap = $urandom_range(1, 18) - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    //------------------------------------------------------------------
    // Stimulus. Each instruction is sent as a bundle: the opcode and its
    // operand bytes, every byte it may read that was never written, and
    // then the execute request itself.
    //------------------------------------------------------------------

    task automatic queue_request(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data);
        cpu_request_t r;
        r.command     = cmd;
        r.mem_address = addr;
        r.mem_data    = data;
        pending_requests.push_back(r);
    endtask

    task automatic store_byte(logic [15:0] addr, logic [7:0] data);
        queue_request(CMD_MEM_WR, addr, data);
        planned_bytes[addr] = data;
    endtask

    function automatic bit is_defined(logic [15:0] addr);
        return planned_bytes.exists(addr) || mem_written[addr];
    endfunction

    function automatic logic [7:0] byte_at(logic [15:0] addr);
        return planned_bytes.exists(addr) ? planned_bytes[addr] : shadow_mem[addr];
    endfunction

    task automatic define_byte(logic [15:0] addr);
        if (!is_defined(addr))
            store_byte(addr, $urandom_range(0, 255));
    endtask

    // Waits until every queued request has been taken, so that the shadow
    // state is current before the next bundle is planned.
    task automatic drain_requests();
        @(posedge clk);
        while (pending_requests.size() != 0 || req.valid)
            @(posedge clk);
        planned_bytes.delete();
    endtask

    // With reuse set, whatever byte already sits at the pc is executed, if that byte is defined.
    task automatic run_op(bit reuse, logic [7:0] op, logic [7:0] b1, logic [7:0] b2);
        logic [15:0] pc;
        logic [15:0] target;
        drain_requests();
        pc = reg_pc;
        if (reuse && is_defined(pc))
        begin
            define_byte(pc + 16'd1);
            define_byte(pc + 16'd2);
        end
        else
        begin
            store_byte(pc, op);
            store_byte(pc + 16'd1, b1);
            store_byte(pc + 16'd2, b2);
        end
        define_byte(pair_value(2));
        define_byte(reg_sp);
        define_byte(reg_sp + 16'd1);
        target = {byte_at(pc + 16'd2), byte_at(pc + 16'd1)};
        define_byte(target);
        define_byte(target + 16'd1);
        queue_request(CMD_EXEC, $urandom_range(0, 65535), $urandom_range(0, 255));
    endtask

    logic [7:0] op_pool [] = '{
        OP_NOP, OP_LD_BCNN, OP_DJNZ, OP_LD_DENN, OP_JR, OP_JR_NZ, OP_LD_HLNN, OP_ST_HL,
        OP_INC_HL, OP_JR_Z, OP_LD_HLM, OP_JR_NC, OP_LD_SP, OP_ST_A, OP_INC_M, OP_LD_MN,
        OP_JR_C, OP_LD_AM, OP_INC_A, OP_DEC_A, OP_LD_AN, OP_LD_BN, OP_HALT, OP_LD_MA,
        OP_ADD_M, OP_SUB_B, OP_CP_M, OP_POP_BC, OP_JP, OP_ADD_N, OP_RET, OP_CALL,
        OP_POP_DE, OP_SUB_N, OP_POP_HL, OP_PUSH_HL, OP_EX_DEHL, OP_XOR_N, OP_POP_AF,
        OP_PUSH_AF, OP_OR_N, OP_CP_N, OP_PREFIX
    };

    initial
    begin
        logic [15:0] addr;
        int          choice;
        fail_count      = 0;
        quiet_phase     = 1'b0;
        hold_off_cycles = 0;
        access_count    = 0;
        reg_a = '0; reg_f = '0; reg_sp = '0; reg_pc = '0; halted = 1'b0;
        tstate_sum = '0; low_sp = '0; low_sp_seen = 1'b0;
        for (int i = 0; i < 6; i++)
            reg_bank[i] = '0;
        for (int i = 0; i < 65536; i++)
            mem_written[i] = 1'b0;

        @(posedge rst_n);

        // Directed part: address extremes, an ignored command, then instructions
        // from most instruction groups with the flag corner cases.
        drain_requests();
        store_byte(16'hFFFF, 8'hFF);
        store_byte(16'h0000, 8'h00);
        queue_request(CMD_MEM_RD, 16'hFFFF, 8'h00);
        queue_request(CMD_IGNORED, 16'hFFFF, 8'hFF);
        run_op(1'b0, OP_LD_SP, 8'h00, 8'h00);
        run_op(1'b0, OP_LD_AN, 8'h7F, 8'h00);
        run_op(1'b0, OP_ADD_N, 8'h01, 8'h00);   // signed overflow and half carry
        run_op(1'b0, OP_SUB_N, 8'h81, 8'h00);   // borrow out of bit 7
        run_op(1'b0, OP_CP_N, 8'hFF, 8'h00);
        run_op(1'b0, OP_XOR_N, 8'hFF, 8'h00);
        run_op(1'b0, OP_OR_N, 8'h00, 8'h00);
        run_op(1'b0, OP_LD_AN, 8'h7F, 8'h00);
        run_op(1'b0, OP_INC_A, 8'h00, 8'h00);   // 7F to 80
        run_op(1'b0, OP_DEC_A, 8'h00, 8'h00);   // 80 to 7F
        run_op(1'b0, OP_LD_BN, 8'h01, 8'h00);
        run_op(1'b0, OP_DJNZ, 8'hFE, 8'h00);    // counter runs out, no branch
        run_op(1'b0, OP_JR_Z, 8'h10, 8'h00);
        run_op(1'b0, OP_JR_NC, 8'h80, 8'h00);
        run_op(1'b0, OP_CALL, 8'h00, 8'h40);
        run_op(1'b0, OP_PUSH_AF, 8'h00, 8'h00);
        run_op(1'b0, OP_POP_BC, 8'h00, 8'h00);
        run_op(1'b0, OP_LD_HLNN, 8'h00, 8'h80);
        run_op(1'b0, OP_LD_MN, 8'hFF, 8'h00);
        run_op(1'b0, OP_INC_M, 8'h00, 8'h00);
        run_op(1'b0, OP_ADD_M, 8'h00, 8'h00);
        run_op(1'b0, OP_ST_HL, 8'hFF, 8'hFF);   // second byte wraps to address 0
        run_op(1'b0, OP_LD_HLM, 8'hFF, 8'hFF);
        run_op(1'b0, OP_EX_DEHL, 8'h00, 8'h00);
        run_op(1'b0, OP_HALT, 8'h00, 8'h00);
        run_op(1'b0, OP_PREFIX, 8'h00, 8'h00);  // outside the subset
        run_op(1'b0, OP_RET, 8'h00, 8'h00);

        // Random programs with some memory traffic and ignored commands mixed in.
        for (int n = 0; n < 110; n++)
        begin
            if (n == 35)
                hold_off_cycles = 400;
            if (n == 70)
            begin
                drain_requests();
                while (owed_events.size() != 0)
                    @(posedge clk);
            end
            if (n == 95)
                quiet_phase = 1'b1;
            choice = $urandom_range(0, 99);
            if (choice < 55)
                run_op(1'b0, op_pool[$urandom_range(0, op_pool.size() - 1)],
                       $urandom_range(0, 255), $urandom_range(0, 255));
            else if (choice < 70)
                run_op(1'b0, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255));
            else if (choice < 85)
                run_op(1'b1, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255));
            else
            begin
                drain_requests();
                addr = $urandom_range(0, 65535);
                store_byte(addr, $urandom_range(0, 255));
                queue_request(CMD_MEM_RD, addr, $urandom_range(0, 255));
                queue_request(CMD_MEM_RD, reg_pc, $urandom_range(0, 255));
                if (!is_defined(reg_pc))
                    void'(pending_requests.pop_back());
                queue_request(CMD_IGNORED, $urandom_range(0, 65535), $urandom_range(0, 255));
            end
        end

        drain_requests();
        while (owed_events.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
src/cis_pkg.sv
src/cis_req_if.sv
src/cis_rsp_if.sv
src/cis_ctrl.sv
src/cis_dpath.sv
src/cpu_instruction_step_subset.sv
tb/tb_cpu_instruction_step_subset.sv
